[hdl/c_subset_tokenizer_core_macros.svh]
// Assertion macros shared by the checker of the tokenizer core.
`ifndef C_SUBSET_TOKENIZER_CORE_MACROS_SVH
`define C_SUBSET_TOKENIZER_CORE_MACROS_SVH

// Property checked on every clock edge outside reset.
`define CST_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that is also checked while reset is applied.
`define CST_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/cst_pkg.sv]
// Package of the tokenizer core: token codes, character classes and the keyword table.
`default_nettype none
package cst_pkg;

  localparam int KEYWORD_MAX_LEN_DEF = 9;
  localparam int POS_BITS_DEF        = 16;

  localparam int KW_COUNT   = 23;
  localparam int KW_LEN_MAX = 9;
  localparam int QDEPTH     = 4;

  localparam logic [6:0] T_IDENT    = 7'd0;
  localparam logic [6:0] T_INT      = 7'd1;
  localparam logic [6:0] T_CHAR     = 7'd2;
  localparam logic [6:0] T_STRING   = 7'd3;
  localparam logic [6:0] T_EOF      = 7'd4;
  localparam logic [6:0] T_KW0      = 7'd5;
  localparam logic [6:0] T_SLASH    = 7'd48;
  localparam logic [6:0] T_SLASH_EQ = 7'd49;
  localparam logic [6:0] T_ERR_OVF  = 7'd67;
  localparam logic [6:0] T_ERR_CHAR = 7'd68;
  localparam logic [6:0] T_NONE     = 7'd0;

  // One result word.
  typedef struct packed {
    logic [6:0]  kind;
    logic [15:0] line;
    logic [15:0] col;
    logic [62:0] value;
    logic [7:0]  bad;
    logic        last;
  } res_t;

  // Keyword text, right-aligned, first character in the highest used byte.
  localparam logic [KW_LEN_MAX*8-1:0] KW_TEXT [KW_COUNT] = '{
    72'("int"), 72'("char"), 72'("bool"), 72'("void"), 72'("struct"), 72'("class"),
    72'("public"), 72'("private"), 72'("protected"), 72'("if"), 72'("else"),
    72'("while"), 72'("for"), 72'("return"), 72'("break"), 72'("continue"),
    72'("true"), 72'("false"), 72'("new"), 72'("delete"), 72'("this"),
    72'("nullptr"), 72'("sizeof")
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd4, 4'd4, 4'd4, 4'd6, 4'd5, 4'd6, 4'd7, 4'd9, 4'd2, 4'd4,
    4'd5, 4'd3, 4'd6, 4'd5, 4'd8, 4'd4, 4'd5, 4'd3, 4'd6, 4'd4, 4'd7, 4'd6
  };

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0a;
  endfunction

  // Characters that may pair with a following one.
  function automatic logic is_op(input logic [7:0] c);
    return c == ":" || c == "+" || c == "-" || c == "*" || c == "=" ||
           c == "!" || c == "<" || c == ">" || c == "&" || c == "|";
  endfunction

  // Punctuators that always stand alone; zero when the byte is not one.
  function automatic logic [6:0] single_punct(input logic [7:0] c);
    logic [6:0] r;
    case (c)
      "(":     r = 7'd28;
      ")":     r = 7'd29;
      "{":     r = 7'd30;
      "}":     r = 7'd31;
      "[":     r = 7'd32;
      "]":     r = 7'd33;
      ";":     r = 7'd34;
      ",":     r = 7'd35;
      ".":     r = 7'd38;
      "%":     r = 7'd50;
      "^":     r = 7'd65;
      "~":     r = 7'd66;
      default: r = T_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] op_single(input logic [7:0] c);
    logic [6:0] r;
    case (c)
      ":":     r = 7'd36;
      "+":     r = 7'd39;
      "-":     r = 7'd42;
      "*":     r = 7'd46;
      "=":     r = 7'd51;
      "!":     r = 7'd53;
      "<":     r = 7'd55;
      ">":     r = 7'd58;
      "&":     r = 7'd61;
      default: r = 7'd63;
    endcase
    return r;
  endfunction

  // Two-character punctuator, or zero when the pair is not one.
  function automatic logic [6:0] op_pair(input logic [7:0] a, input logic [7:0] b);
    logic [6:0] r;
    r = T_NONE;
    case (a)
      ":": if (b == ":") r = 7'd37;
      "+": begin
        if (b == "+") r = 7'd40;
        else if (b == "=") r = 7'd41;
      end
      "-": begin
        if (b == ">") r = 7'd43;
        else if (b == "-") r = 7'd44;
        else if (b == "=") r = 7'd45;
      end
      "*": if (b == "=") r = 7'd47;
      "=": if (b == "=") r = 7'd52;
      "!": if (b == "=") r = 7'd54;
      "<": begin
        if (b == "=") r = 7'd56;
        else if (b == "<") r = 7'd57;
      end
      ">": begin
        if (b == "=") r = 7'd59;
        else if (b == ">") r = 7'd60;
      end
      "&": if (b == "&") r = 7'd62;
      "|": if (b == "|") r = 7'd64;
      default: r = T_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] esc_value(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      "n":     r = 8'd10;
      "t":     r = 8'd9;
      "0":     r = 8'd0;
      default: r = c;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/cst_kwmatch.sv]
// Keyword matcher: compares the buffered identifier prefix with the keyword table.
`default_nettype none
module cst_kwmatch #(
  parameter int KEYWORD_MAX_LEN = cst_pkg::KEYWORD_MAX_LEN_DEF
) (
  input  wire logic [7:0]  prefix [KEYWORD_MAX_LEN],
  input  wire logic [15:0] tok_len,
  output logic             hit,
  output logic [6:0]       kw_kind
);

  // Each keyword is checked in parallel; at most one can match.
  always_comb begin
    logic eq;
    hit     = 1'b0;
    kw_kind = cst_pkg::T_IDENT;
    for (int k = 0; k < cst_pkg::KW_COUNT; k++) begin
      eq = (tok_len == 16'(cst_pkg::KW_LEN[k]));
      for (int i = 0; i < cst_pkg::KW_LEN_MAX; i++) begin
        if (i < int'(cst_pkg::KW_LEN[k])) begin
          if (prefix[i] != cst_pkg::KW_TEXT[k][8*(int'(cst_pkg::KW_LEN[k])-1-i) +: 8])
            eq = 1'b0;
        end
      end
      if (eq) begin
        hit     = 1'b1;
        kw_kind = cst_pkg::T_KW0 + 7'(k);
      end
    end
  end

endmodule
`default_nettype wire

[hdl/cst_outq.sv]
// Result queue: takes up to two words a cycle and hands out one while the receiver is ready.
`default_nettype none
module cst_outq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push0,
  input  wire cst_pkg::res_t   data0,
  input  wire logic            push1,
  input  wire cst_pkg::res_t   data1,
  output logic                 room2,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output cst_pkg::res_t        out_data
);

  localparam int PW = $clog2(cst_pkg::QDEPTH);

  cst_pkg::res_t   q_r [cst_pkg::QDEPTH];
  logic [PW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [PW:0]     cnt_r, cnt_nxt;
  logic            pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = q_r[rd_r];
  assign room2     = (cnt_r <= (PW+1)'(cst_pkg::QDEPTH - 2));
  assign pop       = out_valid && out_ready;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_nxt  = wr_r + PW'(push0) + PW'(push1);
    rd_nxt  = rd_r + PW'(pop);
    cnt_nxt = cnt_r + (PW+1)'(push0) + (PW+1)'(push1) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push0) q_r[wr_r] <= data0;
    if (push1) q_r[wr_r + PW'(1)] <= data1;
  end

endmodule
`default_nettype wire

[hdl/c_subset_tokenizer_core.sv]
// Top level of the tokenizer core: input register, lexer state and result queue.
//
// The in_ channel carries one source byte per word (in_tuser = 0) or an
// end-of-input mark (in_tuser = 1). The out_ channel carries tokens: the
// token code in out_tuser, position, value and offending byte in out_tdata,
// and out_tlast high on the last token caused by one input word.
// A word is taken into an input register, lexed from there once the queue
// has room for two more words, and written into a four-word result queue;
// tokens are offered from the queue in the order they were written, and
// each leaves it when the receiver takes it. One input word is
// taken every cycle while the queue holds at most two words, so the
// sustained rate is one byte per cycle; a word may yield two tokens, and
// then the output side sets the pace. When the receiver stalls, tokens wait
// in the queue and in_tready falls once the queue cannot take two more.
// Reset clears the lexer to the state between tokens at line 1, column 1
// and empties the queue; end of input returns to the same state. After an
// error token, bytes are dropped until end of input, which then gives no
// token.
`default_nettype none
module c_subset_tokenizer_core #(
  parameter int KEYWORD_MAX_LEN = cst_pkg::KEYWORD_MAX_LEN_DEF,
  parameter int POS_BITS        = cst_pkg::POS_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] char_code
  input  wire logic         in_tuser,   // [0] kind
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [103:0]      out_tdata,  // [15:0] start_line, [31:16] start_col,
                                        // [94:32] token_value, [102:95] bad_char, [103] zero
  output logic [6:0]        out_tuser,  // [6:0] token_kind
  output logic              out_tlast   // last
);

  localparam int PIDX = $clog2(KEYWORD_MAX_LEN);

  localparam logic [3:0] M_IDLE     = 4'd0;
  localparam logic [3:0] M_SLASH    = 4'd1;
  localparam logic [3:0] M_OP       = 4'd2;
  localparam logic [3:0] M_LINE     = 4'd3;
  localparam logic [3:0] M_BLOCK    = 4'd4;
  localparam logic [3:0] M_IDENT    = 4'd5;
  localparam logic [3:0] M_NUM      = 4'd6;
  localparam logic [3:0] M_CH_OPEN  = 4'd7;
  localparam logic [3:0] M_CH_ESC   = 4'd8;
  localparam logic [3:0] M_CH_CLOSE = 4'd9;
  localparam logic [3:0] M_STR      = 4'd10;
  localparam logic [3:0] M_STR_ESC  = 4'd11;
  localparam logic [3:0] M_ERR      = 4'd12;

  // Input register.
  logic        s_valid_r;
  logic        s_kind_r;
  logic [7:0]  s_char_r;
  logic        fire, room2;

  // Lexer state.
  logic [3:0]          mode_r, mode_nxt;
  logic [7:0]          pend_r, pend_nxt;
  logic [POS_BITS-1:0] cur_line_r, cur_line_nxt, cur_col_r, cur_col_nxt;
  logic [POS_BITS-1:0] tok_line_r, tok_line_nxt, tok_col_r, tok_col_nxt;
  logic [62:0]         accum_r, accum_nxt;
  logic [15:0]         tok_len_r, tok_len_nxt;
  logic                pstar_r, pstar_nxt;
  logic [7:0]          prefix_r [KEYWORD_MAX_LEN];
  logic                pref_we;
  logic [PIDX-1:0]     pref_idx;

  logic        kw_hit;
  logic [6:0]  kw_kind;

  // Token closed by this word (old start position) and token started by it.
  logic        a_v, b_v, sb;
  logic [6:0]  a_kind, b_kind;
  logic [62:0] a_val;
  logic [7:0]  b_bad;
  logic [66:0] prod;
  logic [15:0] len_inc;
  cst_pkg::res_t res_a, res_b, q_out;
  logic [POS_BITS+15:0] tl_ext, tc_ext, cl_ext, cc_ext;

  assign fire      = s_valid_r && room2;
  assign in_tready = !s_valid_r || room2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_tready) begin
      s_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s_kind_r <= in_tuser;
      s_char_r <= in_tdata;
    end
  end

  cst_kwmatch #(
    .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN)
  ) u_kwmatch (
    .prefix  (prefix_r),
    .tok_len (tok_len_r),
    .hit     (kw_hit),
    .kw_kind (kw_kind)
  );

  assign prod    = ({4'b0, accum_r} << 3) + ({4'b0, accum_r} << 1)
                 + 67'(s_char_r - 8'h30);
  assign len_inc = (&tok_len_r) ? tok_len_r : tok_len_r + 16'd1;

  // Next state of the lexer for the word in the input register.
  always_comb begin
    mode_nxt     = mode_r;
    pend_nxt     = pend_r;
    cur_line_nxt = cur_line_r;
    cur_col_nxt  = cur_col_r;
    tok_line_nxt = tok_line_r;
    tok_col_nxt  = tok_col_r;
    accum_nxt    = accum_r;
    tok_len_nxt  = tok_len_r;
    pstar_nxt    = pstar_r;
    pref_we      = 1'b0;
    pref_idx     = tok_len_r[PIDX-1:0];
    a_v          = 1'b0;
    a_kind       = cst_pkg::T_NONE;
    a_val        = '0;
    b_v          = 1'b0;
    b_kind       = cst_pkg::T_NONE;
    b_bad        = '0;
    sb           = 1'b0;

    if (s_kind_r) begin
      // End of input: flush the open token, then the end token.
      if (mode_r != M_ERR) begin
        case (mode_r)
          M_SLASH: begin a_v = 1'b1; a_kind = cst_pkg::T_SLASH; end
          M_OP:    begin a_v = 1'b1; a_kind = cst_pkg::op_single(pend_r); end
          M_IDENT: begin
            a_v    = 1'b1;
            a_kind = kw_hit ? kw_kind : cst_pkg::T_IDENT;
            a_val  = kw_hit ? '0 : 63'(tok_len_r);
          end
          M_NUM:   begin a_v = 1'b1; a_kind = cst_pkg::T_INT; a_val = accum_r; end
          M_CH_OPEN, M_CH_ESC: begin a_v = 1'b1; a_kind = cst_pkg::T_CHAR; end
          M_CH_CLOSE: begin a_v = 1'b1; a_kind = cst_pkg::T_CHAR; a_val = accum_r; end
          M_STR, M_STR_ESC: begin
            a_v = 1'b1; a_kind = cst_pkg::T_STRING; a_val = 63'(tok_len_r);
          end
          default: a_v = 1'b0;
        endcase
        b_v    = 1'b1;
        b_kind = cst_pkg::T_EOF;
      end
      mode_nxt     = M_IDLE;
      pend_nxt     = '0;
      cur_line_nxt = POS_BITS'(1);
      cur_col_nxt  = POS_BITS'(1);
      tok_line_nxt = POS_BITS'(1);
      tok_col_nxt  = POS_BITS'(1);
      accum_nxt    = '0;
      tok_len_nxt  = '0;
      pstar_nxt    = 1'b0;
    end else begin
      case (mode_r)
        M_IDLE: sb = 1'b1;
        M_SLASH: begin
          if (s_char_r == "/") mode_nxt = M_LINE;
          else if (s_char_r == "*") begin
            mode_nxt  = M_BLOCK;
            pstar_nxt = 1'b0;
          end else if (s_char_r == "=") begin
            a_v = 1'b1; a_kind = cst_pkg::T_SLASH_EQ; mode_nxt = M_IDLE;
          end else begin
            a_v = 1'b1; a_kind = cst_pkg::T_SLASH; sb = 1'b1;
          end
        end
        M_OP: begin
          a_v = 1'b1;
          if (cst_pkg::op_pair(pend_r, s_char_r) != cst_pkg::T_NONE) begin
            a_kind   = cst_pkg::op_pair(pend_r, s_char_r);
            mode_nxt = M_IDLE;
          end else begin
            a_kind = cst_pkg::op_single(pend_r);
            sb     = 1'b1;
          end
        end
        M_LINE: if (s_char_r == 8'h0a) mode_nxt = M_IDLE;
        M_BLOCK: begin
          if (pstar_r && s_char_r == "/") begin
            mode_nxt  = M_IDLE;
            pstar_nxt = 1'b0;
          end else begin
            pstar_nxt = (s_char_r == "*");
          end
        end
        M_IDENT: begin
          if (cst_pkg::is_alpha(s_char_r) || cst_pkg::is_digit(s_char_r)) begin
            pref_we     = (tok_len_r < 16'(KEYWORD_MAX_LEN));
            tok_len_nxt = len_inc;
          end else begin
            a_v    = 1'b1;
            a_kind = kw_hit ? kw_kind : cst_pkg::T_IDENT;
            a_val  = kw_hit ? '0 : 63'(tok_len_r);
            sb     = 1'b1;
          end
        end
        M_NUM: begin
          if (cst_pkg::is_digit(s_char_r)) begin
            if (prod[66:63] != 4'd0) begin
              a_v = 1'b1; a_kind = cst_pkg::T_ERR_OVF; mode_nxt = M_ERR;
            end else begin
              accum_nxt = prod[62:0];
            end
          end else begin
            a_v = 1'b1; a_kind = cst_pkg::T_INT; a_val = accum_r; sb = 1'b1;
          end
        end
        M_CH_OPEN: begin
          if (s_char_r == 8'h5c) mode_nxt = M_CH_ESC;
          else begin
            accum_nxt = 63'(s_char_r);
            mode_nxt  = M_CH_CLOSE;
          end
        end
        M_CH_ESC: begin
          accum_nxt = 63'(cst_pkg::esc_value(s_char_r));
          mode_nxt  = M_CH_CLOSE;
        end
        M_CH_CLOSE: begin
          a_v = 1'b1; a_kind = cst_pkg::T_CHAR; a_val = accum_r;
          if (s_char_r == 8'h27) mode_nxt = M_IDLE;
          else sb = 1'b1;
        end
        M_STR: begin
          if (s_char_r == 8'h22) begin
            a_v = 1'b1; a_kind = cst_pkg::T_STRING; a_val = 63'(tok_len_r);
            mode_nxt = M_IDLE;
          end else if (s_char_r == 8'h5c) mode_nxt = M_STR_ESC;
          else tok_len_nxt = len_inc;
        end
        M_STR_ESC: begin
          tok_len_nxt = len_inc;
          mode_nxt    = M_STR;
        end
        default: mode_nxt = M_ERR;
      endcase

      // Start of a new token with this byte.
      if (sb) begin
        tok_line_nxt = cur_line_r;
        tok_col_nxt  = cur_col_r;
        mode_nxt     = M_IDLE;
        if (cst_pkg::is_blank(s_char_r)) begin
          mode_nxt = M_IDLE;
        end else if (cst_pkg::is_digit(s_char_r)) begin
          mode_nxt  = M_NUM;
          accum_nxt = 63'(s_char_r - 8'h30);
        end else if (cst_pkg::is_alpha(s_char_r)) begin
          mode_nxt    = M_IDENT;
          pref_we     = 1'b1;
          pref_idx    = '0;
          tok_len_nxt = 16'd1;
        end else if (s_char_r == "/") begin
          mode_nxt = M_SLASH;
        end else if (s_char_r == 8'h27) begin
          mode_nxt  = M_CH_OPEN;
          accum_nxt = '0;
        end else if (s_char_r == 8'h22) begin
          mode_nxt    = M_STR;
          tok_len_nxt = '0;
        end else if (cst_pkg::single_punct(s_char_r) != cst_pkg::T_NONE) begin
          b_v    = 1'b1;
          b_kind = cst_pkg::single_punct(s_char_r);
        end else if (cst_pkg::is_op(s_char_r)) begin
          mode_nxt = M_OP;
          pend_nxt = s_char_r;
        end else begin
          b_v      = 1'b1;
          b_kind   = cst_pkg::T_ERR_CHAR;
          b_bad    = s_char_r;
          mode_nxt = M_ERR;
        end
      end

      // Position of the next byte, saturating.
      if (s_char_r == 8'h0a) begin
        if (!(&cur_line_r)) cur_line_nxt = cur_line_r + POS_BITS'(1);
        cur_col_nxt = POS_BITS'(1);
      end else if (!(&cur_col_r)) begin
        cur_col_nxt = cur_col_r + POS_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= M_IDLE;
      pend_r     <= '0;
      cur_line_r <= POS_BITS'(1);
      cur_col_r  <= POS_BITS'(1);
      tok_line_r <= POS_BITS'(1);
      tok_col_r  <= POS_BITS'(1);
      accum_r    <= '0;
      tok_len_r  <= '0;
      pstar_r    <= 1'b0;
    end else if (fire) begin
      mode_r     <= mode_nxt;
      pend_r     <= pend_nxt;
      cur_line_r <= cur_line_nxt;
      cur_col_r  <= cur_col_nxt;
      tok_line_r <= tok_line_nxt;
      tok_col_r  <= tok_col_nxt;
      accum_r    <= accum_nxt;
      tok_len_r  <= tok_len_nxt;
      pstar_r    <= pstar_nxt;
    end
  end

  // Identifier prefix buffer.
  always_ff @(posedge clk) begin
    if (fire && pref_we) prefix_r[pref_idx] <= s_char_r;
  end

  // Result words; positions carry their low 16 bits.
  assign tl_ext = {16'b0, tok_line_r};
  assign tc_ext = {16'b0, tok_col_r};
  assign cl_ext = {16'b0, cur_line_r};
  assign cc_ext = {16'b0, cur_col_r};

  always_comb begin
    res_a.kind  = a_kind;
    res_a.line  = tl_ext[15:0];
    res_a.col   = tc_ext[15:0];
    res_a.value = a_val;
    res_a.bad   = '0;
    res_a.last  = !b_v;
    res_b.kind  = b_kind;
    res_b.line  = cl_ext[15:0];
    res_b.col   = cc_ext[15:0];
    res_b.value = '0;
    res_b.bad   = b_bad;
    res_b.last  = 1'b1;
  end

  cst_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push0     (fire && (a_v || b_v)),
    .data0     (a_v ? res_a : res_b),
    .push1     (fire && a_v && b_v),
    .data1     (res_b),
    .room2     (room2),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (q_out)
  );

  assign out_tdata = {1'b0, q_out.bad, q_out.value, q_out.col, q_out.line};
  assign out_tuser = q_out.kind;
  assign out_tlast = q_out.last;

endmodule
`default_nettype wire

[hdl/cst_chk.sv]
// Port checker of the tokenizer core and its binding.
`default_nettype none
`include "c_subset_tokenizer_core_macros.svh"
module cst_chk (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [103:0] out_tdata,
  input wire logic [6:0]   out_tuser,
  input wire logic         out_tlast
);

  logic         stall;
  logic         not_err;
  logic [111:0] out_bus;
  logic [7:0]   out_bad;

  assign stall   = out_tvalid && !out_tready;
  assign not_err = out_tvalid && (out_tuser != cst_pkg::T_ERR_CHAR);
  assign out_bus = {out_tlast, out_tuser, out_tdata};
  assign out_bad = out_tdata[102:95];

  // The queue is empty in the cycle after reset.
  `CST_ASSERT_RST(a_rst_empty, clk, !rst_n |=> !out_tvalid, "tokens shown after reset")

  // The input side is ready in the cycle after reset.
  `CST_ASSERT_RST(a_rst_ready, clk, !rst_n |=> in_tready, "input not ready after reset")

  // A stalled token stays offered with the same contents.
  `CST_ASSERT(a_hold, clk, rst_n, stall |=> out_tvalid && $stable(out_bus), "stalled token changed")

  // Token codes stay in the defined range.
  `CST_ASSERT(a_kind_range, clk, rst_n, out_tvalid |-> out_tuser <= cst_pkg::T_ERR_CHAR, "token code out of range")

  // Only the unexpected-character error carries an offending byte.
  `CST_ASSERT(a_bad_only_err, clk, rst_n, not_err |-> out_bad == 8'd0, "stray offending byte")

endmodule

bind c_subset_tokenizer_core cst_chk u_cst_chk (.*);
`default_nettype wire
